>>> rtl/core/tfr_pkg.sv
// Shared types and constants for the telemetry frame receiver.
// No dependencies; used by every module of the block.
package tfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h00;
    localparam logic [7:0] HDR_SECOND = 8'h01;

    localparam int FRAME_LEN = 20;
    localparam int SUM_LEN   = 19;
    localparam int POS_W     = 5;
    localparam int NUM_WORDS = 9;
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;

    // 9 sensor words + frame counter byte
    localparam int M_DATA_W  = NUM_WORDS * WORD_W + BYTE_W;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(SUM_LEN);

    localparam logic [1:0] PH_HUNT0   = 2'd0;
    localparam logic [1:0] PH_HUNT1   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic signed [WORD_W-1:0] word_t;

    // finished frame, from the collector to the output stage
    typedef struct packed {
        logic                  valid;
        logic                  sum_ok;
        byte_t                 frame_count;
        word_t [NUM_WORDS-1:0] words;
    } frame_res_t;

    // collector status seen by the flow control
    typedef struct packed {
        logic at_last;
    } coll_stat_t;

endpackage

>>> rtl/core/telemetry_frame_receiver.sv
// Top level of the telemetry frame receiver.
// Depends on tfr_pkg, tfr_frame_collector and tfr_out_stage.
//
// Takes one byte per transfer, every cycle while s_tready is high. It hunts for
// the header 0x00 0x01, collects 20 payload bytes and, on the last one,
// registers a frame: nine little-endian signed words, the frame counter and a
// checksum-match flag. A frame appears on the m_ side the cycle after its last
// byte. Input is held off only when the last byte of a frame is due while the
// previous frame still sits unacknowledged in the single output register.
module telemetry_frame_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] byte_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] angle_x,
    // [79:64] angle_y, [95:80] angle_z, [111:96] temp_inside,
    // [127:112] temp_outside, [143:128] altitude_raw, [151:144] frame_count
    output logic [tfr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [0:0]                    m_tuser    // [0] sum_ok
);

    tfr_pkg::frame_res_t res;
    tfr_pkg::coll_stat_t stat;
    logic                in_fire;

    assign s_tready = !stat.at_last || !m_tvalid || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    tfr_frame_collector u_coll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .res     (res),
        .stat    (stat)
    );

    tfr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/core/tfr_frame_collector.sv
// Header hunt, payload capture and running checksum of the frame receiver.
// Depends on tfr_pkg.
module tfr_frame_collector (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  tfr_pkg::byte_t      in_byte,
    output tfr_pkg::frame_res_t res,
    output tfr_pkg::coll_stat_t stat
);

    logic [1:0]                 phase_reg, phase_next;
    logic [tfr_pkg::POS_W-1:0]  pos_reg, pos_next;
    tfr_pkg::byte_t             sum_reg, sum_next;
    tfr_pkg::byte_t             store_reg [tfr_pkg::SUM_LEN];
    logic                       store_we;
    logic                       emit;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        emit       = 1'b0;
        if (in_fire) begin
            unique case (phase_reg)
                tfr_pkg::PH_HUNT1: begin
                    if (in_byte == tfr_pkg::HDR_SECOND) begin
                        pos_next   = '0;
                        sum_next   = '0;
                        phase_next = tfr_pkg::PH_PAYLOAD;
                    end else begin
                        phase_next = tfr_pkg::PH_HUNT0;
                    end
                end
                tfr_pkg::PH_PAYLOAD: begin
                    if (pos_reg < tfr_pkg::POS_LAST) begin
                        store_we = 1'b1;
                        sum_next = sum_reg + in_byte;
                        pos_next = pos_reg + 1'b1;
                    end else begin
                        emit       = 1'b1;
                        pos_next   = '0;
                        phase_next = tfr_pkg::PH_HUNT0;
                    end
                end
                default: begin
                    phase_next = (in_byte == tfr_pkg::HDR_FIRST) ? tfr_pkg::PH_HUNT1
                                                                  : tfr_pkg::PH_HUNT0;
                end
            endcase
        end
    end

    always_comb begin
        res.valid       = emit;
        res.sum_ok      = (sum_reg == in_byte);
        res.frame_count = store_reg[tfr_pkg::SUM_LEN-1];
        for (int k = 0; k < tfr_pkg::NUM_WORDS; k++) begin
            res.words[k] = {store_reg[2*k+1], store_reg[2*k]};
        end
        stat.at_last = (phase_reg == tfr_pkg::PH_PAYLOAD) && (pos_reg >= tfr_pkg::POS_LAST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tfr_pkg::PH_HUNT0;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < tfr_pkg::SUM_LEN; i++) begin
            if (store_we && (pos_reg == tfr_pkg::POS_W'(i))) begin
                store_reg[i] <= in_byte;
            end
        end
    end

endmodule

>>> rtl/core/tfr_out_stage.sv
// Result register of the frame receiver: holds one frame until transferred.
// Depends on tfr_pkg.
module tfr_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tfr_pkg::frame_res_t              res,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [tfr_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [0:0]                       m_tuser
);

    logic                            valid_reg, valid_next;
    logic [tfr_pkg::M_DATA_W-1:0]    data_reg;
    logic                            ok_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res.valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            data_reg <= {res.frame_count, res.words};
            ok_reg   <= res.sum_ok;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = ok_reg;

endmodule

>>> rtl/core/tfr_checker.sv
// Port-level checks for the telemetry frame receiver, bound to the top level.
// Depends on tfr_pkg and telemetry_frame_receiver.
module tfr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tfr_pkg::M_DATA_W-1:0]  m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_frame_needs_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without input transfer");

    a_drain_without_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result repeated");

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
